// ===== src/lps_pkg.sv =====
// shared types, constants and the pattern step rom for the led pattern sequencer
package lps_pkg;

    localparam int MAX_STEPS  = 8;
    localparam int TIME_WIDTH = 12;

    // step counts and lengths up to 31
    localparam int LEN_W = 5;

    localparam int NUM_PATTERNS = 9;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_PLAY = 2'd1,
        FUNC_STOP = 2'd2
    } func_t;

    localparam logic [3:0] PAT_INSERT    = 4'd0;
    localparam logic [3:0] PAT_EXTRACT   = 4'd1;
    localparam logic [3:0] PAT_AMBIGUOUS = 4'd2;
    localparam logic [3:0] PAT_PASS      = 4'd3;
    localparam logic [3:0] PAT_FAIL      = 4'd4;
    localparam logic [3:0] PAT_MESH      = 4'd5;
    localparam logic [3:0] PAT_IDLE      = 4'd6;
    localparam logic [3:0] PAT_HOLD      = 4'd7;
    localparam logic [3:0] PAT_RESET     = 4'd8;
    localparam logic [3:0] PAT_SLEEP     = 4'd9;

    typedef struct packed {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
    } colour_t;

    typedef struct packed {
        colour_t               colour;
        logic [TIME_WIDTH-1:0] lit_ms;
        logic [TIME_WIDTH-1:0] dark_ms;
    } step_t;

    typedef struct packed {
        logic [LEN_W-1:0]      count;
        logic                  loops;
    } pat_info_t;

    typedef struct packed {
        logic [3:0]            active_pattern;
        logic [2:0]            step_index;
        logic                  gap_phase;
        logic [TIME_WIDTH-1:0] ms_remaining;
        logic                  busy;
        colour_t               shown;
    } state_t;

    function automatic step_t mk_step(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input int lit, input int dark);
        step_t s;
        s.colour.red   = r;
        s.colour.green = g;
        s.colour.blue  = b;
        s.lit_ms       = TIME_WIDTH'(lit);
        s.dark_ms      = TIME_WIDTH'(dark);
        return s;
    endfunction

    function automatic pat_info_t pattern_info(input logic [3:0] p);
        pat_info_t info;
        info = '0;
        unique case (p)
            PAT_INSERT:    info = '{count: LEN_W'(1), loops: 1'b0};
            PAT_EXTRACT:   info = '{count: LEN_W'(1), loops: 1'b0};
            PAT_AMBIGUOUS: info = '{count: LEN_W'(1), loops: 1'b0};
            PAT_PASS:      info = '{count: LEN_W'(1), loops: 1'b0};
            PAT_FAIL:      info = '{count: LEN_W'(2), loops: 1'b0};
            PAT_MESH:      info = '{count: LEN_W'(8), loops: 1'b1};
            PAT_IDLE:      info = '{count: LEN_W'(1), loops: 1'b1};
            PAT_HOLD:      info = '{count: LEN_W'(8), loops: 1'b1};
            PAT_RESET:     info = '{count: LEN_W'(1), loops: 1'b1};
            default:       info = '0;
        endcase
        // patterns longer than the step limit are cut short
        if (info.count > LEN_W'(MAX_STEPS))
        begin
            info.count = LEN_W'(MAX_STEPS);
        end
        return info;
    endfunction

    function automatic step_t pattern_step(input logic [3:0] p, input logic [2:0] s);
        step_t st;
        st = '0;
        unique case ({p, s})
            {PAT_INSERT,    3'd0}: st = mk_step(8'd0,   8'd255, 8'd0,   100,  0);
            {PAT_EXTRACT,   3'd0}: st = mk_step(8'd255, 8'd0,   8'd0,   100,  0);
            {PAT_AMBIGUOUS, 3'd0}: st = mk_step(8'd255, 8'd180, 8'd0,   100,  0);
            {PAT_PASS,      3'd0}: st = mk_step(8'd0,   8'd255, 8'd0,   2000, 0);
            {PAT_FAIL,      3'd0}: st = mk_step(8'd255, 8'd0,   8'd0,   100,  100);
            {PAT_FAIL,      3'd1}: st = mk_step(8'd255, 8'd0,   8'd0,   100,  0);
            {PAT_MESH,      3'd0}: st = mk_step(8'd0,   8'd0,   8'd32,  200,  0);
            {PAT_MESH,      3'd1}: st = mk_step(8'd0,   8'd0,   8'd64,  200,  0);
            {PAT_MESH,      3'd2}: st = mk_step(8'd0,   8'd0,   8'd128, 200,  0);
            {PAT_MESH,      3'd3}: st = mk_step(8'd0,   8'd0,   8'd255, 200,  0);
            {PAT_MESH,      3'd4}: st = mk_step(8'd0,   8'd0,   8'd128, 200,  0);
            {PAT_MESH,      3'd5}: st = mk_step(8'd0,   8'd0,   8'd64,  200,  0);
            {PAT_MESH,      3'd6}: st = mk_step(8'd0,   8'd0,   8'd32,  200,  0);
            {PAT_MESH,      3'd7}: st = mk_step(8'd0,   8'd0,   8'd0,   200,  0);
            {PAT_IDLE,      3'd0}: st = mk_step(8'd30,  8'd30,  8'd30,  200,  2800);
            {PAT_HOLD,      3'd0}: st = mk_step(8'd32,  8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd1}: st = mk_step(8'd64,  8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd2}: st = mk_step(8'd128, 8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd3}: st = mk_step(8'd255, 8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd4}: st = mk_step(8'd128, 8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd5}: st = mk_step(8'd64,  8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd6}: st = mk_step(8'd32,  8'd0,   8'd0,   200,  0);
            {PAT_HOLD,      3'd7}: st = mk_step(8'd0,   8'd0,   8'd0,   200,  0);
            {PAT_RESET,     3'd0}: st = mk_step(8'd255, 8'd0,   8'd0,   100,  100);
            default:               st = '0;
        endcase
        return st;
    endfunction

endpackage

// ===== src/lps_step_logic.sv =====
// next-state logic of the sequencer for one command word
module lps_step_logic (
    input  logic [1:0]      func,
    input  logic [3:0]      pattern,
    input  lps_pkg::state_t cur,
    output lps_pkg::state_t nxt
);

    lps_pkg::step_t    cur_step;
    lps_pkg::step_t    new_step;
    lps_pkg::step_t    play_step;
    lps_pkg::pat_info_t info;
    logic [lps_pkg::LEN_W-1:0] step_inc;
    logic              at_end;
    logic [2:0]        enter_idx;

    assign cur_step  = lps_pkg::pattern_step(cur.active_pattern, cur.step_index);
    assign info      = lps_pkg::pattern_info(cur.active_pattern);
    assign step_inc  = lps_pkg::LEN_W'(cur.step_index) + lps_pkg::LEN_W'(1);
    assign at_end    = (step_inc >= info.count);
    assign enter_idx = at_end ? 3'd0 : step_inc[2:0];
    assign new_step  = lps_pkg::pattern_step(cur.active_pattern, enter_idx);
    assign play_step = lps_pkg::pattern_step(pattern, 3'd0);

    always_comb
    begin
        nxt = cur;
        unique case (func)
            lps_pkg::FUNC_TICK:
            begin
                if (cur.busy)
                begin
                    if (cur.ms_remaining <= lps_pkg::TIME_WIDTH'(1))
                    begin
                        if (!cur.gap_phase && (cur_step.dark_ms != '0))
                        begin
                            // lit phase over, go dark for the gap
                            nxt.gap_phase    = 1'b1;
                            nxt.shown        = '0;
                            nxt.ms_remaining = cur_step.dark_ms;
                        end
                        else if (at_end && !info.loops)
                        begin
                            nxt = '0;
                        end
                        else
                        begin
                            nxt.step_index   = enter_idx;
                            nxt.gap_phase    = 1'b0;
                            nxt.shown        = new_step.colour;
                            nxt.ms_remaining = new_step.lit_ms;
                        end
                    end
                    else
                    begin
                        nxt.ms_remaining = cur.ms_remaining - lps_pkg::TIME_WIDTH'(1);
                    end
                end
            end
            lps_pkg::FUNC_PLAY:
            begin
                nxt = '0;
                // sleep and unknown pattern numbers leave the block dark and idle
                if (pattern < 4'(lps_pkg::NUM_PATTERNS))
                begin
                    nxt.active_pattern = pattern;
                    nxt.busy           = 1'b1;
                    nxt.shown          = play_step.colour;
                    nxt.ms_remaining   = play_step.lit_ms;
                end
            end
            lps_pkg::FUNC_STOP:
            begin
                nxt = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== src/led_pattern_sequencer.sv =====
// top level of the led pattern sequencer: input register, state and result register
//
// usage
//   slave channel takes one command word per handshake: s_tuser carries the
//   function (tick, play, stop), s_tdata carries the pattern number for play
//   master channel returns one word for every command: the colour now shown
//   and a running flag
//   m_tvalid rises when a command moves from the input register into the state
//   and result registers; with m_tready high one word is taken every cycle, so
//   the sustained rate is one command per cycle, set by the single state update
//   path through the step rom lookup into the state and result registers
//   when the receiver stalls, one finished word waits in the result register
//   and one more command is held in the input register; s_tready drops only
//   when both are full
//   reset clears the state: the led is dark, no pattern runs, both
//   registers are empty
//   one tick command stands for one millisecond of pattern time
module led_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [3:0] pattern, [7:4] zero
    input  logic [1:0]  s_tuser,  // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // [7:0] red, [15:8] green, [23:16] blue, [24] running
);

    logic            in_valid_reg;
    logic [1:0]      func_reg;
    logic [3:0]      pattern_reg;
    lps_pkg::state_t state_reg;
    lps_pkg::state_t state_next;
    logic            out_valid_reg;
    logic [24:0]     result_reg;
    logic            advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lps_step_logic u_step (
        .func    (func_reg),
        .pattern (pattern_reg),
        .cur     (state_reg),
        .nxt     (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            func_reg    <= s_tuser;
            pattern_reg <= s_tdata[3:0];
        end
        if (advance)
        begin
            result_reg <= {state_next.busy, state_next.shown.blue,
                           state_next.shown.green, state_next.shown.red};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg};

endmodule

// ===== verif/tb_top.sv =====
// testbench for the led pattern sequencer: random command streams checked against a step-rom tracker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // the function code with no meaning; the block answers it without a change
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int MAX_SHOWN = 10;
    localparam int ITEMS = 700;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       running;
    } led_word_t;

    class led_scoreboard;
        logic [3:0]                     pattern;
        logic [2:0]                     step;
        logic                           in_gap;
        logic [lps_pkg::TIME_WIDTH-1:0] remaining;
        logic                           busy;
        logic [23:0]                    colour;
        led_word_t                      expected_leds[$];
        int unsigned                    mismatches;

        function new();
            mismatches = 0;
            go_dark();
        endfunction

        function void go_dark();
            pattern   = '0;
            step      = '0;
            in_gap    = 1'b0;
            remaining = '0;
            busy      = 1'b0;
            colour    = '0;
        endfunction

        function void lookup_step(input logic [3:0] p, input logic [2:0] s,
                                  output logic [23:0] rgb, output int lit, output int dark);
            logic [7:0] ramp [8];
            ramp = '{8'd32, 8'd64, 8'd128, 8'd255, 8'd128, 8'd64, 8'd32, 8'd0};
            rgb  = '0;
            lit  = 0;
            dark = 0;
            case (p)
                lps_pkg::PAT_INSERT:    begin rgb = 24'h00ff00; lit = 100; end
                lps_pkg::PAT_EXTRACT:   begin rgb = 24'hff0000; lit = 100; end
                lps_pkg::PAT_AMBIGUOUS: begin rgb = {8'd255, 8'd180, 8'd0}; lit = 100; end
                lps_pkg::PAT_PASS:      begin rgb = 24'h00ff00; lit = 2000; end
                lps_pkg::PAT_FAIL:
                begin
                    rgb  = 24'hff0000;
                    lit  = 100;
                    dark = (s == 3'd0) ? 100 : 0;
                end
                lps_pkg::PAT_MESH:      begin rgb = {16'h0, ramp[s]}; lit = 200; end
                lps_pkg::PAT_IDLE:      begin rgb = {3{8'd30}}; lit = 200; dark = 2800; end
                lps_pkg::PAT_HOLD:      begin rgb = {ramp[s], 16'h0}; lit = 200; end
                lps_pkg::PAT_RESET:     begin rgb = 24'hff0000; lit = 100; dark = 100; end
                default:       ;
            endcase
        endfunction

        function int steps_in(input logic [3:0] p);
            int n;
            case (p)
                lps_pkg::PAT_FAIL:                   n = 2;
                lps_pkg::PAT_MESH, lps_pkg::PAT_HOLD: n = 8;
                default:                             n = (p < lps_pkg::NUM_PATTERNS) ? 1 : 0;
            endcase
            return (n > lps_pkg::MAX_STEPS) ? lps_pkg::MAX_STEPS : n;
        endfunction

        function bit repeats(input logic [3:0] p);
            return (p == lps_pkg::PAT_MESH || p == lps_pkg::PAT_IDLE ||
                    p == lps_pkg::PAT_HOLD || p == lps_pkg::PAT_RESET);
        endfunction

        function void load_step(input int idx);
            logic [23:0] rgb;
            int          lit;
            int          dark;
            step   = 3'(idx);
            in_gap = 1'b0;
            lookup_step(pattern, step, rgb, lit, dark);
            colour    = rgb;
            remaining = lps_pkg::TIME_WIDTH'(lit);
        endfunction

        function void end_phase();
            logic [23:0] rgb;
            int          lit;
            int          dark;
            lookup_step(pattern, step, rgb, lit, dark);
            if (!in_gap && dark > 0)
            begin
                in_gap    = 1'b1;
                colour    = '0;
                remaining = lps_pkg::TIME_WIDTH'(dark);
            end
            else if (int'(step) + 1 >= steps_in(pattern))
            begin
                if (repeats(pattern))
                    load_step(0);
                else
                    go_dark();
            end
            else
            begin
                load_step(int'(step) + 1);
            end
        endfunction

        function void note_command(input logic [1:0] f, input logic [3:0] p);
            led_word_t want;
            case (f)
                lps_pkg::FUNC_TICK:
                begin
                    if (busy)
                    begin
                        if (remaining <= 1)
                        begin
                            remaining = '0;
                            end_phase();
                        end
                        else
                        begin
                            remaining = remaining - 1'b1;
                        end
                    end
                end
                lps_pkg::FUNC_PLAY:
                begin
                    go_dark();
                    if (p < lps_pkg::NUM_PATTERNS)
                    begin
                        pattern = p;
                        busy    = 1'b1;
                        load_step(0);
                    end
                end
                lps_pkg::FUNC_STOP: go_dark();
                default:   ;
            endcase
            want.red     = colour[23:16];
            want.green   = colour[15:8];
            want.blue    = colour[7:0];
            want.running = busy;
            expected_leds.push_back(want);
        endfunction

        function void fault(input string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%t mismatch: %s", $realtime, what);
        endfunction

        function void check_led_word(input logic [31:0] word);
            led_word_t want;
            if (expected_leds.size() == 0)
            begin
                fault($sformatf("word %h with nothing expected", word));
                return;
            end
            want = expected_leds.pop_front();
            if (word[7:0] !== want.red || word[15:8] !== want.green ||
                word[23:16] !== want.blue || word[24] !== want.running)
            begin
                fault($sformatf("expected r %0d g %0d b %0d run %0b, got r %0d g %0d b %0d run %0b",
                                want.red, want.green, want.blue, want.running,
                                word[7:0], word[15:8], word[23:16], word[24]));
            end
        endfunction

        function int pending();
            return expected_leds.size();
        endfunction

        function void close_out();
            if (expected_leds.size() != 0)
                fault($sformatf("%0d words never arrived", expected_leds.size()));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [3:0] pattern, [7:4] zero
    logic [1:0]  s_tuser = '0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [7:0] red, [15:8] green, [23:16] blue, [24] running

    bit            steady = 1'b0;
    int            sent = 0;
    led_scoreboard sb;

    led_pattern_sequencer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_led_word(m_tdata);
    end

    // one command word; may idle first, leaves tvalid high after acceptance
    task automatic send_word(input logic [1:0] f, input logic [3:0] p);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, p};
        s_tuser  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(f, p);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // a play (mostly of a real pattern, now and then a random command) followed by a run of mostly ticks
    task automatic run_session(input bit noisy);
        int burst;
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            send_word(lps_pkg::FUNC_PLAY, 4'($urandom_range(0, lps_pkg::NUM_PATTERNS - 1)));
        else if (r < 92)
            send_word(lps_pkg::FUNC_PLAY, 4'($urandom_range(lps_pkg::PAT_SLEEP, 15)));
        else
            send_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
        burst = (steady || $urandom_range(0, 99) < 30) ? $urandom_range(200, 320)
                                                      : $urandom_range(0, 60);
        // keep the whole run near the item budget
        if (burst > ITEMS - sent)
            burst = (ITEMS - sent > 0) ? ITEMS - sent : 0;
        repeat (burst)
        begin
            r = $urandom_range(0, 999);
            if (noisy && r < 15)
                send_word(lps_pkg::FUNC_STOP, 4'($urandom_range(0, 15)));
            else if (noisy && r < 25)
                send_word(lps_pkg::FUNC_PLAY, 4'($urandom_range(0, 15)));
            else if (r < 35)
                send_word(FUNC_NONE, 4'($urandom_range(0, 15)));
            else
                send_word(lps_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        #10ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        int n;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block: unused code, tick and stop change nothing
        send_word(FUNC_NONE, 4'd15);
        send_word(lps_pkg::FUNC_TICK, 4'd0);
        send_word(lps_pkg::FUNC_STOP, 4'd0);
        // every pattern number, including sleep and those above it
        for (n = 0; n < 16; n++)
            send_word(lps_pkg::FUNC_PLAY, 4'(n));
        send_word(lps_pkg::FUNC_PLAY, lps_pkg::PAT_FAIL);
        send_word(lps_pkg::FUNC_TICK, 4'd0);
        send_word(FUNC_NONE, lps_pkg::PAT_MESH);
        send_word(lps_pkg::FUNC_PLAY, lps_pkg::PAT_SLEEP);
        send_word(lps_pkg::FUNC_PLAY, lps_pkg::PAT_HOLD);
        send_word(lps_pkg::FUNC_STOP, 4'd15);
        wait_drained();

        n = 0;
        while (sent < ITEMS)
        begin
            if (n % 3 == 2)
                wait_drained();
            steady = (n == 1);
            run_session($urandom_range(0, 1));
            n++;
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        for (n = 0; n < 2000 && sb.pending() != 0; n++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
